// ----- hdl/touch_coordinate_filter_map_core_assert.svh -----
`ifndef TOUCH_COORDINATE_FILTER_MAP_CORE_ASSERT_SVH
`define TOUCH_COORDINATE_FILTER_MAP_CORE_ASSERT_SVH

// Same-cycle implication on clk, cut while arst_n is low.
`define TCFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication on clk, cut while arst_n is low.
`define TCFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/tcfm_pkg.sv -----
`timescale 1ns / 1ps
package tcfm_pkg;

	localparam int COORD_W = 12;
	localparam int CFG_W   = 12;
	localparam int ROT_W   = 2;
	localparam int IDX_W   = 3;
	localparam int QUOT_W  = COORD_W + 1;
	localparam int OUT_W   = 4 * COORD_W;
	localparam int NUM_LANES = 2;

	localparam logic [CFG_W-1:0] CAL_MAX_RST = 12'd4095;
	localparam logic [CFG_W-1:0] H_RES_RST   = 12'd320;
	localparam logic [CFG_W-1:0] V_RES_RST   = 12'd240;

	typedef enum logic [IDX_W-1:0] {
		REG_H_CAL_MIN = 3'd0,
		REG_H_CAL_MAX = 3'd1,
		REG_V_CAL_MIN = 3'd2,
		REG_V_CAL_MAX = 3'd3,
		REG_H_RES     = 3'd4,
		REG_V_RES     = 3'd5,
		REG_ROTATION  = 3'd6
	} reg_index_t;

	typedef enum logic [ROT_W-1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef struct packed {
		logic [CFG_W-1:0] h_cal_min;
		logic [CFG_W-1:0] h_cal_max;
		logic [CFG_W-1:0] v_cal_min;
		logic [CFG_W-1:0] v_cal_max;
		logic [CFG_W-1:0] h_resolution;
		logic [CFG_W-1:0] v_resolution;
		rot_t             rotation;
	} cal_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// magnitude width of raw - lo
	function automatic int mag_w(input int s);
		return (s > COORD_W) ? s : COORD_W;
	endfunction

	// width of |raw - lo| * res
	function automatic int num_w(input int s);
		return mag_w(s) + CFG_W;
	endfunction

	// one lane: {zero, res, den, num}
	function automatic int lane_w(input int s);
		return num_w(s) + 2 * CFG_W + 1;
	endfunction

	// one queue entry: {lane y, lane x, y_filt, x_filt, pen}
	function automatic int entry_w(input int s);
		return 1 + 2 * COORD_W + NUM_LANES * lane_w(s);
	endfunction

	function automatic int in_w(input int s);
		return ((6 * s + 7) / 8) * 8;
	endfunction

endpackage

// ----- hdl/tcfm_front.sv -----
`timescale 1ns / 1ps
module tcfm_front import tcfm_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [in_w(SAMPLE_BITS)-1:0]       s_tdata,
	input  logic                               s_tuser,
	input  cal_cfg_t                           cfg,
	input  fifo_stat_t                         q_stat,
	output logic                               push,
	output logic [entry_w(SAMPLE_BITS)-1:0]    entry
);

	localparam int S      = SAMPLE_BITS;
	localparam int MAG_W  = mag_w(S);
	localparam int DIFF_W = MAG_W + 1;
	localparam int SPAN_W = CFG_W + 1;
	localparam int NUM_W  = num_w(S);

	function automatic logic [S-1:0] best_two(input logic [S-1:0] a, input logic [S-1:0] b,
			input logic [S-1:0] c);
		logic [S-1:0] dab;
		logic [S-1:0] dac;
		logic [S-1:0] dbc;
		logic [S:0]   sum;
		dab = (a > b) ? a - b : b - a;
		dac = (a > c) ? a - c : c - a;
		dbc = (b > c) ? b - c : c - b;
		priority if (dab <= dac && dab <= dbc) begin
			sum = {1'b0, a} + {1'b0, b};
		end else if (dac <= dab && dac <= dbc) begin
			sum = {1'b0, a} + {1'b0, c};
		end else begin
			sum = {1'b0, b} + {1'b0, c};
		end
		return sum[S:1];
	endfunction

	logic adv;

	// stage 1: best-two filter
	logic             vld_s1;
	logic             pen_s1;
	logic [MAG_W-1:0] xf_s1;
	logic [MAG_W-1:0] yf_s1;

	// stage 2: lane operands
	logic               vld_s2;
	logic               pen_s2;
	logic [COORD_W-1:0] xf_s2;
	logic [COORD_W-1:0] yf_s2;
	logic [MAG_W-1:0]   mag_s2  [NUM_LANES];
	logic [CFG_W-1:0]   den_s2  [NUM_LANES];
	logic [CFG_W-1:0]   res_s2  [NUM_LANES];
	logic               zero_s2 [NUM_LANES];

	// stage 3: product
	logic               vld_s3;
	logic               pen_s3;
	logic [COORD_W-1:0] xf_s3;
	logic [COORD_W-1:0] yf_s3;
	logic [NUM_W-1:0]   num_s3  [NUM_LANES];
	logic [CFG_W-1:0]   den_s3  [NUM_LANES];
	logic [CFG_W-1:0]   res_s3  [NUM_LANES];
	logic               zero_s3 [NUM_LANES];

	logic [MAG_W-1:0]  raw_l  [NUM_LANES];
	logic [CFG_W-1:0]  lo_l   [NUM_LANES];
	logic [CFG_W-1:0]  hi_l   [NUM_LANES];
	logic [CFG_W-1:0]  res_l  [NUM_LANES];
	logic [DIFF_W-1:0] diff_l [NUM_LANES];
	logic [DIFF_W-1:0] dmag_l [NUM_LANES];
	logic [SPAN_W-1:0] span_l [NUM_LANES];
	logic [SPAN_W-1:0] smag_l [NUM_LANES];
	logic              zero_l [NUM_LANES];

	assign adv      = !vld_s3 || !q_stat.full;
	assign s_tready = adv;
	assign push     = vld_s3 && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pen_s1 <= s_tuser;
			xf_s1  <= MAG_W'(best_two(s_tdata[0*S +: S], s_tdata[2*S +: S], s_tdata[4*S +: S]));
			yf_s1  <= MAG_W'(best_two(s_tdata[1*S +: S], s_tdata[3*S +: S], s_tdata[5*S +: S]));
		end
	end

	// rotation picks source axis and calibration end points per lane (0 = x, 1 = y)
	always_comb begin
		raw_l[0] = xf_s1;
		lo_l[0]  = cfg.h_cal_min;
		hi_l[0]  = cfg.h_cal_max;
		res_l[0] = cfg.h_resolution;
		raw_l[1] = yf_s1;
		lo_l[1]  = cfg.v_cal_min;
		hi_l[1]  = cfg.v_cal_max;
		res_l[1] = cfg.v_resolution;
		unique case (cfg.rotation)
			ROT_0: begin
			end
			ROT_90: begin
				raw_l[0] = yf_s1;
				lo_l[0]  = cfg.v_cal_min;
				hi_l[0]  = cfg.v_cal_max;
				res_l[0] = cfg.v_resolution;
				raw_l[1] = xf_s1;
				lo_l[1]  = cfg.h_cal_max;
				hi_l[1]  = cfg.h_cal_min;
				res_l[1] = cfg.h_resolution;
			end
			ROT_180: begin
				lo_l[0]  = cfg.v_cal_max;
				hi_l[0]  = cfg.v_cal_min;
				lo_l[1]  = cfg.h_cal_max;
				hi_l[1]  = cfg.h_cal_min;
			end
			ROT_270: begin
				raw_l[0] = yf_s1;
				lo_l[0]  = cfg.v_cal_max;
				hi_l[0]  = cfg.v_cal_min;
				res_l[0] = cfg.v_resolution;
				raw_l[1] = xf_s1;
				lo_l[1]  = cfg.h_cal_min;
				hi_l[1]  = cfg.h_cal_max;
				res_l[1] = cfg.h_resolution;
			end
			default: begin
			end
		endcase
		for (int l = 0; l < NUM_LANES; l++) begin
			diff_l[l] = {1'b0, raw_l[l]} - DIFF_W'(lo_l[l]);
			span_l[l] = {1'b0, hi_l[l]} - {1'b0, lo_l[l]};
			dmag_l[l] = diff_l[l][DIFF_W-1] ? (~diff_l[l] + 1'b1) : diff_l[l];
			smag_l[l] = span_l[l][SPAN_W-1] ? (~span_l[l] + 1'b1) : span_l[l];
			// zero span, or opposite signs: the quotient clamps to zero
			zero_l[l] = (span_l[l] == '0) || (diff_l[l][DIFF_W-1] != span_l[l][SPAN_W-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pen_s2 <= pen_s1;
			xf_s2  <= xf_s1[COORD_W-1:0];
			yf_s2  <= yf_s1[COORD_W-1:0];
			for (int l = 0; l < NUM_LANES; l++) begin
				mag_s2[l]  <= dmag_l[l][MAG_W-1:0];
				den_s2[l]  <= smag_l[l][CFG_W-1:0];
				res_s2[l]  <= res_l[l];
				zero_s2[l] <= zero_l[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pen_s3 <= pen_s2;
			xf_s3  <= xf_s2;
			yf_s3  <= yf_s2;
			for (int l = 0; l < NUM_LANES; l++) begin
				num_s3[l]  <= NUM_W'(mag_s2[l]) * NUM_W'(res_s2[l]);
				den_s3[l]  <= den_s2[l];
				res_s3[l]  <= res_s2[l];
				zero_s3[l] <= zero_s2[l];
			end
		end
	end

	assign entry = {zero_s3[1], res_s3[1], den_s3[1], num_s3[1],
			zero_s3[0], res_s3[0], den_s3[0], num_s3[0],
			yf_s3, xf_s3, pen_s3};

endmodule

// ----- hdl/tcfm_fifo.sv -----
`timescale 1ns / 1ps
module tcfm_fifo import tcfm_pkg::*; #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output fifo_stat_t       stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/tcfm_div.sv -----
`timescale 1ns / 1ps
module tcfm_div import tcfm_pkg::*; #(
	parameter int NUM_W = 24
) (
	input  logic               clk,
	input  logic               adv,
	input  logic [NUM_W-1:0]   num,
	input  logic [CFG_W-1:0]   den,
	input  logic [CFG_W-1:0]   res,
	input  logic               zero,
	output logic [COORD_W-1:0] quot
);

	localparam int CMP_W = NUM_W + 1;

	logic [NUM_W-1:0]  rem_s  [QUOT_W+1];
	logic [QUOT_W-1:0] quo_s  [QUOT_W+1];
	logic [CFG_W-1:0]  den_s  [QUOT_W+1];
	logic [CFG_W-1:0]  res_s  [QUOT_W+1];
	logic              zero_s [QUOT_W+1];
	logic              sat_s  [QUOT_W+1];

	logic [CMP_W-1:0] den_top;

	// quotient would not fit QUOT_W bits: it clamps to res anyway
	assign den_top = CMP_W'({den, {QUOT_W{1'b0}}});

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0]  <= num;
			quo_s[0]  <= '0;
			den_s[0]  <= den;
			res_s[0]  <= res;
			zero_s[0] <= zero;
			sat_s[0]  <= ({1'b0, num} >= den_top);
		end
	end

	// one restoring step per stage, most significant quotient bit first
	for (genvar k = 0; k < QUOT_W; k++) begin : g_step
		localparam int SH = QUOT_W - 1 - k;
		logic [CMP_W-1:0] trial;

		assign trial = {1'b0, rem_s[k]} - (CMP_W'(den_s[k]) << SH);

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[k+1]  <= trial[CMP_W-1] ? rem_s[k] : trial[NUM_W-1:0];
				// lower quotient bits are still zero at this stage
				quo_s[k+1]  <= quo_s[k] | (QUOT_W'(!trial[CMP_W-1]) << SH);
				den_s[k+1]  <= den_s[k];
				res_s[k+1]  <= res_s[k];
				zero_s[k+1] <= zero_s[k];
				sat_s[k+1]  <= sat_s[k];
			end
		end
	end

	always_comb begin
		priority if (zero_s[QUOT_W]) begin
			quot = '0;
		end else if (sat_s[QUOT_W] || quo_s[QUOT_W] > {1'b0, res_s[QUOT_W]}) begin
			quot = res_s[QUOT_W];
		end else begin
			quot = quo_s[QUOT_W][COORD_W-1:0];
		end
	end

endmodule

// ----- hdl/tcfm_back.sv -----
`timescale 1ns / 1ps
module tcfm_back import tcfm_pkg::*; #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fifo_stat_t                      q_stat,
	output logic                            pop,
	input  logic [entry_w(SAMPLE_BITS)-1:0] entry,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [OUT_W-1:0]                m_tdata,
	output logic                            m_tuser
);

	localparam int NUM_W  = num_w(SAMPLE_BITS);
	localparam int LANE_W = lane_w(SAMPLE_BITS);
	localparam int LANE0  = 1 + 2 * COORD_W;

	logic adv;

	logic               vld_s [QUOT_W+1];
	logic               pen_s [QUOT_W+1];
	logic [COORD_W-1:0] xf_s  [QUOT_W+1];
	logic [COORD_W-1:0] yf_s  [QUOT_W+1];

	logic [COORD_W-1:0] quot_l [NUM_LANES];

	logic               m_tvalid_q;
	logic               pressed_q;
	logic [COORD_W-1:0] x_filt_q;
	logic [COORD_W-1:0] y_filt_q;
	logic [COORD_W-1:0] x_pix_q;
	logic [COORD_W-1:0] y_pix_q;

	assign adv = !m_tvalid_q || m_tready;
	assign pop = adv && !q_stat.empty;

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		localparam int BASE = LANE0 + l * LANE_W;

		tcfm_div #(
			.NUM_W (NUM_W)
		) u_div (
			.clk  (clk),
			.adv  (adv),
			.num  (entry[BASE +: NUM_W]),
			.den  (entry[BASE + NUM_W +: CFG_W]),
			.res  (entry[BASE + NUM_W + CFG_W +: CFG_W]),
			.zero (entry[BASE + NUM_W + 2 * CFG_W]),
			.quot (quot_l[l])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= QUOT_W; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[0] <= !q_stat.empty;
			for (int k = 0; k < QUOT_W; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pen_s[0] <= entry[0];
			xf_s[0]  <= entry[1 +: COORD_W];
			yf_s[0]  <= entry[1 + COORD_W +: COORD_W];
			for (int k = 0; k < QUOT_W; k++) begin
				pen_s[k+1] <= pen_s[k];
				xf_s[k+1]  <= xf_s[k];
				yf_s[k+1]  <= yf_s[k];
			end
		end
	end

	// output register doubles as the held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			pressed_q  <= 1'b0;
			x_filt_q   <= '0;
			y_filt_q   <= '0;
			x_pix_q    <= '0;
			y_pix_q    <= '0;
		end else if (adv) begin
			m_tvalid_q <= vld_s[QUOT_W];
			if (vld_s[QUOT_W]) begin
				pressed_q <= pen_s[QUOT_W];
				if (pen_s[QUOT_W]) begin
					x_filt_q <= xf_s[QUOT_W];
					y_filt_q <= yf_s[QUOT_W];
					x_pix_q  <= quot_l[0];
					y_pix_q  <= quot_l[1];
				end
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = pressed_q;
	assign m_tdata  = {y_pix_q, x_pix_q, y_filt_q, x_filt_q};

endmodule

// ----- hdl/touch_coordinate_filter_map_core.sv -----
`timescale 1ns / 1ps
// Resistive touch filter and calibration map. Each input transaction carries a pen-down flag
// and three X and three Y conversions; while the pen is down each axis keeps the rounded-down
// average of its two closest samples (ties go to pairs a-b, then a-c, then b-c), rotation then
// picks the source axis and calibration end points, and each screen coordinate becomes
// (raw - lo) * res / (hi - lo), truncated toward zero and clamped to 0..res (zero span gives 0).
// A pen-up transaction returns pressed = 0 with the last held values. One result comes out for
// every input transaction, in order. The block takes one transaction per clock while s_tready is
// high; results pass through a 3-stage front end (filter, operand select, multiply), a
// QUEUE_DEPTH-entry queue and the 13-stage restoring quotient pipeline in the back end (one
// quotient bit per stage) to the output register. Either side may stall on its own: the queue
// absorbs output back-pressure before s_tready drops. Calibration registers
// are written through cfg_we / cfg_index / cfg_data and must only change while the block is
// empty.
module touch_coordinate_filter_map_core import tcfm_pkg::*; #(
	parameter int SAMPLE_BITS = 12,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [IDX_W-1:0]             cfg_index,
	input  logic [CFG_W-1:0]             cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// x_sample_a, y_sample_a, x_sample_b, y_sample_b, x_sample_c, y_sample_c, zero pad
	input  logic [in_w(SAMPLE_BITS)-1:0] s_tdata,
	// pen_down
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// x_filtered, y_filtered, x_pixel, y_pixel
	output logic [OUT_W-1:0]             m_tdata,
	// pressed
	output logic                         m_tuser
);

	localparam int ENTRY_W = entry_w(SAMPLE_BITS);

	cal_cfg_t           cfg_q;
	fifo_stat_t         q_stat;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] wr_entry;
	logic [ENTRY_W-1:0] rd_entry;

	// Hold the calibration registers; drop writes to unused indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.h_cal_min    <= '0;
			cfg_q.h_cal_max    <= CAL_MAX_RST;
			cfg_q.v_cal_min    <= '0;
			cfg_q.v_cal_max    <= CAL_MAX_RST;
			cfg_q.h_resolution <= H_RES_RST;
			cfg_q.v_resolution <= V_RES_RST;
			cfg_q.rotation     <= ROT_0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_H_CAL_MIN: cfg_q.h_cal_min    <= cfg_data;
				REG_H_CAL_MAX: cfg_q.h_cal_max    <= cfg_data;
				REG_V_CAL_MIN: cfg_q.v_cal_min    <= cfg_data;
				REG_V_CAL_MAX: cfg_q.v_cal_max    <= cfg_data;
				REG_H_RES:     cfg_q.h_resolution <= cfg_data;
				REG_V_RES:     cfg_q.v_resolution <= cfg_data;
				REG_ROTATION:  cfg_q.rotation     <= rot_t'(cfg_data[ROT_W-1:0]);
				default: begin
				end
			endcase
		end
	end

	// Front end: filter the samples, select operands, form the numerators.
	tcfm_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg      (cfg_q),
		.q_stat   (q_stat),
		.push     (push),
		.entry    (wr_entry)
	);

	// Decoupling queue between the two halves.
	tcfm_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.pop    (pop),
		.rdata  (rd_entry),
		.stat   (q_stat)
	);

	// Back end: divide, clamp, update the held values and present the result.
	tcfm_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop      (pop),
		.entry    (rd_entry),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- hdl/tcfm_checker.sv -----
`timescale 1ns / 1ps
`include "touch_coordinate_filter_map_core_assert.svh"
module tcfm_checker import tcfm_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata,
	input logic             m_tuser
);

	logic [7:0]       pend_q;
	logic [OUT_W-1:0] last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			last_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(s_tvalid && s_tready) - 8'(m_tvalid && m_tready);
			if (m_tvalid && m_tready) begin
				last_q <= m_tdata;
			end
		end
	end

	`TCFM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
	`TCFM_ASSERT_NOW(a_pen_up_held, m_tvalid && !m_tuser, m_tdata == last_q, "pen-up result does not repeat held values")
	`TCFM_ASSERT_NOW(a_no_extra, m_tvalid && m_tready, pend_q != '0, "result without a pending transaction")

endmodule

bind touch_coordinate_filter_map_core tcfm_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
